// ===== rtl/cqc_pkg.sv =====
// ----------------------------------------------------------------------------
// cqc_pkg
// Shared types and constants of the cube map quadtree cell classifier.
// ----------------------------------------------------------------------------
package cqc_pkg;

    localparam int DEF_MAX_DEPTH  = 14;
    localparam int DEF_COORD_BITS = 16;

    localparam int TAG_W   = 16;
    localparam int FACE_W  = 3;
    localparam int DEPTH_W = 4;
    localparam int CELL_W  = 14;
    localparam int PATH_W  = 28;

    typedef enum logic [1:0] {
        QUAD_PU_PV = 2'd0,
        QUAD_NU_PV = 2'd1,
        QUAD_NU_NV = 2'd2,
        QUAD_PU_NV = 2'd3
    } t_quad;

    typedef struct packed {
        logic [FACE_W-1:0] face;
        logic              degen;
        logic [TAG_W-1:0]  tag;
    } t_ctl;

endpackage

// ===== rtl/cqc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// cqc_cfg_if
// Configuration write channel carrying the tree depth register.
// ----------------------------------------------------------------------------
interface cqc_cfg_if
    import cqc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [DEPTH_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/cqc_point_if.sv =====
// ----------------------------------------------------------------------------
// cqc_point_if
// Input channel carrying one point and its tag.
// ----------------------------------------------------------------------------
interface cqc_point_if
    import cqc_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;
    logic [TAG_W-1:0]             point_tag;

    modport source (output valid, output coord_x, output coord_y, output coord_z,
                    output point_tag, input ready);
    modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                    input point_tag, output ready);
endinterface

// ===== rtl/cqc_result_if.sv =====
// ----------------------------------------------------------------------------
// cqc_result_if
// Output channel carrying the face, leaf cell and quadrant path of a point.
// ----------------------------------------------------------------------------
interface cqc_result_if
    import cqc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FACE_W-1:0] face_id;
    logic [CELL_W-1:0] cell_u;
    logic [CELL_W-1:0] cell_v;
    logic [PATH_W-1:0] quad_path;
    logic              degenerate;
    logic [TAG_W-1:0]  tag_out;

    modport source (output valid, output face_id, output cell_u, output cell_v,
                    output quad_path, output degenerate, output tag_out, input ready);
    modport sink   (input valid, input face_id, input cell_u, input cell_v,
                    input quad_path, input degenerate, input tag_out, output ready);
endinterface

// ===== rtl/cubemap_quadtree_cell_classifier.sv =====
// ----------------------------------------------------------------------------
// cubemap_quadtree_cell_classifier
// Classifies points into a cube face and a quadtree leaf cell on that face.
// ----------------------------------------------------------------------------
// Every point passes the face stage and all MAX_DEPTH level cells, whatever tree depth is set.
// One face selection stage is followed by one cell per quadtree level.
// Throughput is one point per cycle while the output is ready; every stage holds its item under stall.
// Synchronous reset clears all stage valid bits and sets r_depth to zero.
// ----------------------------------------------------------------------------
module cubemap_quadtree_cell_classifier
    import cqc_pkg::*;
#(
    parameter int MAX_DEPTH  = DEF_MAX_DEPTH,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cqc_cfg_if.sink       i_cfg,
    cqc_point_if.sink     i_point,
    cqc_result_if.source  o_result
);

    localparam int TW = COORD_BITS + 2;
    localparam int PW = 2 * MAX_DEPTH;

    logic [DEPTH_W-1:0]   r_depth;

    logic                 w_valid [0:MAX_DEPTH];
    logic                 w_ready [0:MAX_DEPTH];
    t_ctl                 w_ctl   [0:MAX_DEPTH];
    logic signed [TW-1:0] w_t_u   [0:MAX_DEPTH];
    logic signed [TW-1:0] w_t_v   [0:MAX_DEPTH];
    logic [COORD_BITS:0]  w_mabs  [0:MAX_DEPTH];
    logic [MAX_DEPTH-1:0] w_cu    [0:MAX_DEPTH];
    logic [MAX_DEPTH-1:0] w_cv    [0:MAX_DEPTH];
    logic [PW-1:0]        w_path  [0:MAX_DEPTH];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else if (i_cfg.valid) begin
            r_depth <= i_cfg.data;
        end
    end

    cqc_face_stage #(
        .COORD_BITS (COORD_BITS),
        .TW         (TW)
    ) u_face (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_point.valid),
        .o_ready (i_point.ready),
        .i_x     (i_point.coord_x),
        .i_y     (i_point.coord_y),
        .i_z     (i_point.coord_z),
        .i_tag   (i_point.point_tag),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_ctl   (w_ctl[0]),
        .o_t_u   (w_t_u[0]),
        .o_t_v   (w_t_v[0]),
        .o_mabs  (w_mabs[0])
    );

    assign w_cu[0]   = '0;
    assign w_cv[0]   = '0;
    assign w_path[0] = '0;

    for (genvar g = 0; g < MAX_DEPTH; g++) begin : g_level
        cqc_level_cell #(
            .COORD_BITS (COORD_BITS),
            .MAX_DEPTH  (MAX_DEPTH),
            .LEVEL      (g),
            .TW         (TW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_depth (r_depth),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_ctl   (w_ctl[g]),
            .i_t_u   (w_t_u[g]),
            .i_t_v   (w_t_v[g]),
            .i_mabs  (w_mabs[g]),
            .i_cu    (w_cu[g]),
            .i_cv    (w_cv[g]),
            .i_path  (w_path[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_ctl   (w_ctl[g+1]),
            .o_t_u   (w_t_u[g+1]),
            .o_t_v   (w_t_v[g+1]),
            .o_mabs  (w_mabs[g+1]),
            .o_cu    (w_cu[g+1]),
            .o_cv    (w_cv[g+1]),
            .o_path  (w_path[g+1])
        );
    end

    assign w_ready[MAX_DEPTH] = o_result.ready;

    assign o_result.valid      = w_valid[MAX_DEPTH];
    assign o_result.face_id    = w_ctl[MAX_DEPTH].face;
    assign o_result.degenerate = w_ctl[MAX_DEPTH].degen;
    assign o_result.tag_out    = w_ctl[MAX_DEPTH].tag;
    assign o_result.cell_u     = CELL_W'(w_cu[MAX_DEPTH]);
    assign o_result.cell_v     = CELL_W'(w_cv[MAX_DEPTH]);
    assign o_result.quad_path  = PATH_W'(w_path[MAX_DEPTH]);

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.degenerate) |->
        (o_result.cell_u == '0 && o_result.cell_v == '0 && o_result.quad_path == '0))
        else $error("degenerate point produced a nonzero cell");

    a_face_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.face_id < FACE_W'(6)))
        else $error("cube face out of range");

    a_depth_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && r_depth == '0) |->
        (o_result.cell_u == '0 && o_result.quad_path == '0))
        else $error("cell path set with zero tree depth");

    a_cell_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |->
        ((o_result.cell_u >> r_depth) == '0 && (o_result.cell_v >> r_depth) == '0))
        else $error("leaf cell exceeds configured depth");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_valid[0] |-> i_point.ready)
        else $error("input stalled with empty face stage");

endmodule

// ===== rtl/cqc_face_stage.sv =====
// ----------------------------------------------------------------------------
// cqc_face_stage
// Selects the major axis and cube face, and seeds the bisection remainders.
// ----------------------------------------------------------------------------
module cqc_face_stage
    import cqc_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int TW         = DEF_COORD_BITS + 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [COORD_BITS-1:0] i_x,
    input  logic signed [COORD_BITS-1:0] i_y,
    input  logic signed [COORD_BITS-1:0] i_z,
    input  logic [TAG_W-1:0]             i_tag,
    output logic                         o_valid,
    input  logic                         i_ready,
    output t_ctl                         o_ctl,
    output logic signed [TW-1:0]         o_t_u,
    output logic signed [TW-1:0]         o_t_v,
    output logic [COORD_BITS:0]          o_mabs
);

    logic                  r_valid;
    t_ctl                  r_ctl;
    logic signed [TW-1:0]  r_t_u;
    logic signed [TW-1:0]  r_t_v;
    logic [COORD_BITS:0]   r_mabs;

    logic [COORD_BITS:0]   w_ax;
    logic [COORD_BITS:0]   w_ay;
    logic [COORD_BITS:0]   w_az;
    logic [1:0]            w_major;
    logic [COORD_BITS:0]   n_mabs;
    logic                  w_neg;
    logic signed [TW-1:0]  n_t_u;
    logic signed [TW-1:0]  n_t_v;
    t_ctl                  n_ctl;
    logic                  w_load;

    function automatic logic [COORD_BITS:0] f_abs(input logic signed [COORD_BITS-1:0] a);
        logic [COORD_BITS:0] s;
        s = {a[COORD_BITS-1], a};
        return s[COORD_BITS] ? (~s + 1'b1) : s;
    endfunction

    always_comb begin
        w_ax    = f_abs(i_x);
        w_ay    = f_abs(i_y);
        w_az    = f_abs(i_z);
        w_major = 2'd0;
        n_mabs  = w_ax;
        w_neg   = i_x[COORD_BITS-1];
        n_t_u   = TW'(i_y);
        n_t_v   = TW'(i_z);
        if (w_ay > w_ax) begin
            w_major = 2'd1;
            n_mabs  = w_ay;
        end
        if (w_az > n_mabs) begin
            w_major = 2'd2;
            n_mabs  = w_az;
        end
        case (w_major)
            2'd1: begin
                w_neg = i_y[COORD_BITS-1];
                n_t_u = TW'(i_z);
                n_t_v = TW'(i_x);
            end
            2'd2: begin
                w_neg = i_z[COORD_BITS-1];
                n_t_u = TW'(i_x);
                n_t_v = TW'(i_y);
            end
            default: begin
                w_neg = i_x[COORD_BITS-1];
                n_t_u = TW'(i_y);
                n_t_v = TW'(i_z);
            end
        endcase
        n_ctl.face  = FACE_W'(w_major) + (w_neg ? FACE_W'(0) : FACE_W'(3));
        n_ctl.degen = (n_mabs == '0);
        n_ctl.tag   = i_tag;
    end

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (w_load) begin
            r_ctl  <= n_ctl;
            r_t_u  <= n_t_u;
            r_t_v  <= n_t_v;
            r_mabs <= n_mabs;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_t_u   = r_t_u;
    assign o_t_v   = r_t_v;
    assign o_mabs  = r_mabs;

endmodule

// ===== rtl/cqc_level_cell.sv =====
// ----------------------------------------------------------------------------
// cqc_level_cell
// One quadtree level: a non-restoring bisection step on both minor axes.
// ----------------------------------------------------------------------------
module cqc_level_cell
    import cqc_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int MAX_DEPTH  = DEF_MAX_DEPTH,
    parameter int LEVEL      = 0,
    parameter int TW         = DEF_COORD_BITS + 2
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [DEPTH_W-1:0]        i_depth,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  t_ctl                      i_ctl,
    input  logic signed [TW-1:0]      i_t_u,
    input  logic signed [TW-1:0]      i_t_v,
    input  logic [COORD_BITS:0]       i_mabs,
    input  logic [MAX_DEPTH-1:0]      i_cu,
    input  logic [MAX_DEPTH-1:0]      i_cv,
    input  logic [2*MAX_DEPTH-1:0]    i_path,
    output logic                      o_valid,
    input  logic                      i_ready,
    output t_ctl                      o_ctl,
    output logic signed [TW-1:0]      o_t_u,
    output logic signed [TW-1:0]      o_t_v,
    output logic [COORD_BITS:0]       o_mabs,
    output logic [MAX_DEPTH-1:0]      o_cu,
    output logic [MAX_DEPTH-1:0]      o_cv,
    output logic [2*MAX_DEPTH-1:0]    o_path
);

    localparam int                 PW  = 2 * MAX_DEPTH;
    localparam int                 POS = 2 * (MAX_DEPTH - 1 - LEVEL);
    localparam logic [DEPTH_W-1:0] LVL = DEPTH_W'(LEVEL);

    logic                  r_valid;
    t_ctl                  r_ctl;
    logic signed [TW-1:0]  r_t_u;
    logic signed [TW-1:0]  r_t_v;
    logic [COORD_BITS:0]   r_mabs;
    logic [MAX_DEPTH-1:0]  r_cu;
    logic [MAX_DEPTH-1:0]  r_cv;
    logic [PW-1:0]         r_path;

    logic                  w_active;
    logic                  w_low_u;
    logic                  w_low_v;
    t_quad                 w_quad;
    logic signed [TW-1:0]  w_m;
    logic signed [TW-1:0]  n_t_u;
    logic signed [TW-1:0]  n_t_v;
    logic [MAX_DEPTH-1:0]  n_cu;
    logic [MAX_DEPTH-1:0]  n_cv;
    logic [PW-1:0]         n_path;
    logic                  w_load;

    always_comb begin
        w_active = !i_ctl.degen && (LVL < i_depth);
        w_low_u  = i_t_u[TW-1];
        w_low_v  = i_t_v[TW-1];
        w_m      = $signed(TW'(i_mabs));
        n_t_u    = w_low_u ? ((i_t_u <<< 1) + w_m) : ((i_t_u <<< 1) - w_m);
        n_t_v    = w_low_v ? ((i_t_v <<< 1) + w_m) : ((i_t_v <<< 1) - w_m);
        case ({w_low_u, w_low_v})
            2'b00:   w_quad = QUAD_PU_PV;
            2'b10:   w_quad = QUAD_NU_PV;
            2'b11:   w_quad = QUAD_NU_NV;
            default: w_quad = QUAD_PU_NV;
        endcase
        n_cu   = i_cu;
        n_cv   = i_cv;
        n_path = i_path;
        if (w_active) begin
            n_cu   = (i_cu << 1) | MAX_DEPTH'(!w_low_u);
            n_cv   = (i_cv << 1) | MAX_DEPTH'(!w_low_v);
            n_path = i_path | (PW'(w_quad) << POS);
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (w_load) begin
            r_ctl  <= i_ctl;
            r_t_u  <= n_t_u;
            r_t_v  <= n_t_v;
            r_mabs <= i_mabs;
            r_cu   <= n_cu;
            r_cv   <= n_cv;
            r_path <= n_path;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_t_u   = r_t_u;
    assign o_t_v   = r_t_v;
    assign o_mabs  = r_mabs;
    assign o_cu    = r_cu;
    assign o_cv    = r_cv;
    assign o_path  = r_path;

endmodule
